[src/slm_pkg.sv]
// slm_pkg: shared sizes, function codes and transfer records for the sorted list merge block.
// No dependencies; imported by slm_front, slm_back and sorted_list_merge_core.
`timescale 1ns / 1ps

package slm_pkg;

  // Store geometry
  localparam int LIST_DEPTH = 32;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Command queue between front and back (power-of-two depth)
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

  // Result queue at the output (two entries)
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_PTR_W = 1;
  localparam int OUTQ_CNT_W = 2;

  // Function codes of an input item
  typedef logic [1:0] func_t;
  localparam func_t FUNC_LOAD_A = 2'd0;
  localparam func_t FUNC_LOAD_B = 2'd1;
  localparam func_t FUNC_MERGE  = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // One queued command
  typedef struct packed {
    func_t func;
    data_t value;
  } cmd_t;

  // One result record
  typedef struct packed {
    data_t merged_value;
    logic  last;
    logic  empty_res;
    logic  overflow;
  } res_t;

endpackage

[src/slm_front.sv]
// slm_front: input side of the merge block; accepts items, drops unused function codes
// and buffers commands in a small queue for the back end. Depends on slm_pkg.
`timescale 1ns / 1ps

module slm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  slm_pkg::func_t    in_func,
  input  slm_pkg::data_t    in_value,
  output logic              in_full,
  output logic              cmd_valid,
  output slm_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);
  import slm_pkg::*;

  cmd_t                  cq_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  accept;
  logic                  keep;
  logic                  take;

  assign in_full   = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign accept    = in_push & ~in_full;
  assign cmd_valid = (cnt_r != '0);
  assign take      = cmd_pop & cmd_valid;
  assign cmd       = cq_r[rd_ptr_r];

  // Classify: only load and merge codes go on to the back end
  always_comb begin
    keep = 1'b0;
    case (in_func) inside
      FUNC_LOAD_A, FUNC_LOAD_B, FUNC_MERGE: keep = accept;
      default:                              keep = 1'b0;
    endcase
  end

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + CMDQ_PTR_W'(keep);
    rd_ptr_nxt = rd_ptr_r + CMDQ_PTR_W'(take);
    cnt_nxt    = cnt_r + CMDQ_CNT_W'(keep) - CMDQ_CNT_W'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (keep) begin
      cq_r[wr_ptr_r] <= '{func: in_func, value: in_value};
    end
  end

endmodule

[src/slm_back.sv]
// slm_back: executes queued commands; holds both list stores, counts and drop flag,
// runs the merge and buffers results in a two-entry queue. Depends on slm_pkg.
`timescale 1ns / 1ps

module slm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  slm_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output slm_pkg::res_t  res
);
  import slm_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic state_r, state_nxt;

  // List stores and registered read ports
  logic [DATA_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic [DATA_WIDTH-1:0] mem_b [LIST_DEPTH];
  logic [DATA_WIDTH-1:0] rd_a_r, rd_b_r;

  logic [CNT_W-1:0] count_a_r, count_a_nxt;
  logic [CNT_W-1:0] count_b_r, count_b_nxt;
  logic [CNT_W-1:0] idx_a_r, idx_a_nxt;
  logic [CNT_W-1:0] idx_b_r, idx_b_nxt;
  logic [CNT_W-1:0] inc_a, inc_b;
  logic             dropped_r, dropped_nxt;

  logic load_a, load_b, start;
  logic full_a, full_b;
  logic a_left, b_left, both_empty, take_a;
  logic step, adv_a, adv_b, done;
  res_t res_nxt;

  // Result queue
  res_t                  oq_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] owr_r, ord_r;
  logic [OUTQ_CNT_W-1:0] ocnt_r;
  logic                  oq_full, opop;

  // Command dispatch
  assign cmd_pop = (state_r == ST_IDLE) & cmd_valid;
  assign load_a  = cmd_pop & (cmd.func == FUNC_LOAD_A);
  assign load_b  = cmd_pop & (cmd.func == FUNC_LOAD_B);
  assign start   = cmd_pop & (cmd.func == FUNC_MERGE);
  assign full_a  = (count_a_r == CNT_W'(LIST_DEPTH));
  assign full_b  = (count_b_r == CNT_W'(LIST_DEPTH));

  // Merge step: compare the two heads, B wins ties
  assign a_left     = (idx_a_r < count_a_r);
  assign b_left     = (idx_b_r < count_b_r);
  assign both_empty = (count_a_r == '0) & (count_b_r == '0);
  assign take_a     = (a_left & b_left) ? ($signed(rd_a_r) < $signed(rd_b_r)) : a_left;
  assign step       = (state_r == ST_MERGE) & ~oq_full;
  assign adv_a      = step & ~both_empty & take_a;
  assign adv_b      = step & ~both_empty & ~take_a;
  assign inc_a      = idx_a_r + CNT_W'(adv_a);
  assign inc_b      = idx_b_r + CNT_W'(adv_b);
  assign done       = step & (both_empty | ((inc_a == count_a_r) & (inc_b == count_b_r)));

  always_comb begin
    res_nxt.merged_value = both_empty ? '0 : (take_a ? data_t'(rd_a_r) : data_t'(rd_b_r));
    res_nxt.last         = done;
    res_nxt.empty_res    = both_empty;
    res_nxt.overflow     = dropped_r;
  end

  // Next state of counts, indexes and flag
  always_comb begin
    state_nxt   = state_r;
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    dropped_nxt = dropped_r;
    idx_a_nxt   = done ? '0 : inc_a;
    idx_b_nxt   = done ? '0 : inc_b;
    unique case (state_r)
      ST_IDLE: begin
        if (load_a) begin
          if (full_a) dropped_nxt = 1'b1;
          else        count_a_nxt = count_a_r + CNT_W'(1);
        end
        if (load_b) begin
          if (full_b) dropped_nxt = 1'b1;
          else        count_b_nxt = count_b_r + CNT_W'(1);
        end
        if (start) state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (done) begin
          count_a_nxt = '0;
          count_b_nxt = '0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_a_r <= '0;
      count_b_r <= '0;
      idx_a_r   <= '0;
      idx_b_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
      idx_a_r   <= idx_a_nxt;
      idx_b_r   <= idx_b_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Store writes and head reads; the read address follows the next index
  always_ff @(posedge clk) begin
    if (load_a && !full_a) begin
      mem_a[count_a_r[ADDR_W-1:0]] <= cmd.value;
    end
    rd_a_r <= mem_a[idx_a_nxt[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_b && !full_b) begin
      mem_b[count_b_r[ADDR_W-1:0]] <= cmd.value;
    end
    rd_b_r <= mem_b[idx_b_nxt[ADDR_W-1:0]];
  end

  // Result queue control
  assign oq_full   = (ocnt_r == OUTQ_CNT_W'(OUTQ_DEPTH));
  assign out_empty = (ocnt_r == '0);
  assign opop      = out_pop & ~out_empty;
  assign res       = oq_r[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owr_r  <= owr_r + OUTQ_PTR_W'(step);
      ord_r  <= ord_r + OUTQ_PTR_W'(opop);
      ocnt_r <= ocnt_r + OUTQ_CNT_W'(step) - OUTQ_CNT_W'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      oq_r[owr_r] <= res_nxt;
    end
  end

endmodule

[src/sorted_list_merge_core.sv]
// sorted_list_merge_core: top level of the two-way merge of sorted lists.
// Depends on slm_pkg, slm_front and slm_back.
`timescale 1ns / 1ps

// Loads (func 0 for list A, func 1 for list B) append one signed element to a
// 32-entry store; loads into a full store are dropped and flagged as overflow on
// the next merge. A merge (func 2) emits every stored element in ascending order,
// list B first on ties, last set on the final result, or a single result with
// empty_res set when both lists are empty; afterwards both lists are empty.
// func 3 is taken and discarded. In the back end a load is executed as it is popped;
// a merge is dispatched and then emits its results (at least one) while the result
// queue has room; each list store has a single read port giving one head per cycle.
// A four-entry command queue lets the input keep taking items while a merge runs,
// and a two-entry result queue absorbs short stalls on the output side.
module sorted_list_merge_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  slm_pkg::func_t in_func,
  input  slm_pkg::data_t in_value,
  output logic           in_full,
  output logic           out_empty,
  input  logic           out_pop,
  output slm_pkg::data_t out_merged_value,
  output logic           out_last,
  output logic           out_empty_res,
  output logic           out_overflow
);
  import slm_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  slm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_func   (in_func),
    .in_value  (in_value),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  slm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  // Result record onto separate ports
  assign out_merged_value = res.merged_value;
  assign out_last         = res.last;
  assign out_empty_res    = res.empty_res;
  assign out_overflow     = res.overflow;

endmodule
